@@ rtl/core/upe_pkg.sv @@
`timescale 1ns / 1ps

package upe_pkg;

   // Register map: index of each register, byte address is 4 * index
   typedef enum logic {
      REG_OUTPUT_ENABLE = 1'b0,
      REG_OUT_CAPACITY  = 1'b1
   } reg_index_type;

   localparam int unsigned CFG_ADDR_WIDTH = 3;
   localparam logic [16:0] CAP_MAX        = 17'h10000;
   localparam logic [19:0] OUT_BYTES_MAX  = 20'hFFFFF;
   localparam logic [7:0]  PERCENT_CHAR   = 8'h25;
   localparam logic [7:0]  NUL_CHAR       = 8'h00;

   // Expansion of one source byte
   typedef struct packed {
      logic       plain;    // passes through as one character
      logic [7:0] char0;
      logic [7:0] char1;
      logic [7:0] char2;
   } enc_type;

   // Uppercase hex digit for a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

@@ rtl/core/upe_encode.sv @@
`timescale 1ns / 1ps

module upe_encode
   import upe_pkg::*;
(
   input  logic [7:0] in_byte,
   output enc_type    enc
);

   always_comb begin
      enc = '0;
      case (1'b1)
         (in_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                          8'h2D, 8'h5F, 8'h2E, 8'h7E}): begin
            enc.plain = 1'b1;
            enc.char0 = in_byte;
         end
         default: begin
            enc.plain = 1'b0;
            enc.char0 = PERCENT_CHAR;
            enc.char1 = hex_digit(in_byte[7:4]);
            enc.char2 = hex_digit(in_byte[3:0]);
         end
      endcase
   end

endmodule

@@ rtl/core/url_percent_encoder_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_stall  one source byte (req_in_byte)
// rsp       out        rsp_valid/rsp_stall  one encoded character plus final counts
// csr       in         APB psel/penable     one 32-bit register write or read
//
// A source byte is held in the input register, then its expansion loads the
// result buffer. The result port moves one character per cycle while rsp is not
// stalled; a byte that passes through yields one character, an escaped byte three.
// Bytes that emit nothing (truncated or measure-only) retire without loading the buffer.
// reset (synchronous) clears counters, valids and config registers to their defaults.
// A stall on rsp holds the current character; req stalls while the input byte cannot retire.

module url_percent_encoder_top
   import upe_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 20
)
(
   input  logic                      clock,
   input  logic                      reset,
   // source bytes
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   // encoded characters
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_is_final,
   output logic [15:0]               rsp_chars_written,
   output logic [19:0]               rsp_bytes_needed,
   // configuration
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CFG_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // compare width covers the count plus carry and the 20-bit size limit
   localparam int unsigned CmpW = (COUNT_WIDTH + 1 > 21) ? COUNT_WIDTH + 1 : 21;
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   // ---------------------------------------------------------------- config
   logic          oe_ff, oe_in;
   logic [16:0]   cap_ff, cap_in;
   logic          cfg_write;
   reg_index_type cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_index = reg_index_type'(paddr[2]);

   always_comb begin
      oe_in  = oe_ff;
      cap_in = cap_ff;
      prdata = '0;
      case (cfg_index)
         REG_OUTPUT_ENABLE: begin
            prdata = {31'd0, oe_ff};
            if (cfg_write) begin
               oe_in = pwdata[0];
            end
         end
         REG_OUT_CAPACITY: begin
            prdata = {15'd0, cap_ff};
            if (cfg_write) begin
               cap_in = pwdata[16:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       req_accept;
   logic       advance;     // input register retires into the result buffer

   assign req_stall  = in_vld_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_accept) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_in_byte;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- encode
   enc_type enc;

   upe_encode u_encode (
      .in_byte (in_byte_ff),
      .enc     (enc)
   );

   logic [COUNT_WIDTH-1:0] needed_ff, needed_in;
   logic [15:0]            written_ff, written_in;

   logic [16:0]            cap_eff;
   logic [16:0]            limit_full;
   logic [COUNT_WIDTH:0]   sum;
   logic                   fits;
   logic [COUNT_WIDTH-1:0] fin_count;
   logic [CmpW-1:0]        fin_wide;
   logic [19:0]            fin_bytes;
   logic                   is_end;

   always_comb begin
      // clamp capacity into 1..65536
      if (cap_ff == 17'd0) begin
         cap_eff = 17'd1;
      end else if (cap_ff > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
      limit_full = cap_eff - 17'd1;

      sum = {1'b0, needed_ff} + (enc.plain ? (COUNT_WIDTH+1)'(1) : (COUNT_WIDTH+1)'(3));

      // all-or-nothing: emit only if the whole expansion fits
      fits = oe_ff && (needed_ff != CountMax) && !sum[COUNT_WIDTH]
             && (CmpW'(sum) <= CmpW'(limit_full));

      fin_count = (needed_ff == CountMax) ? CountMax : needed_ff + 1'b1;
      fin_wide  = CmpW'(fin_count);
      fin_bytes = (fin_wide > CmpW'(OUT_BYTES_MAX)) ? OUT_BYTES_MAX : fin_wide[19:0];

      is_end = (in_byte_ff == NUL_CHAR);
   end

   // ---------------------------------------------------------------- result buffer
   // Hold up to three characters; the head is the output register.
   logic [1:0]  cnt_ff, cnt_in;
   logic [7:0]  ch0_ff, ch0_in, ch1_ff, ch1_in, ch2_ff, ch2_in;
   logic        fin_ff, fin_in;
   logic [15:0] wr_ff, wr_in;
   logic [19:0] nd_ff, nd_in;
   logic        rsp_accept;

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_accept = rsp_valid & ~rsp_stall;
   assign advance    = in_vld_ff & ((cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & rsp_accept));

   always_comb begin
      cnt_in     = cnt_ff;
      ch0_in     = ch0_ff;
      ch1_in     = ch1_ff;
      ch2_in     = ch2_ff;
      fin_in     = fin_ff;
      wr_in      = wr_ff;
      nd_in      = nd_ff;
      needed_in  = needed_ff;
      written_in = written_ff;

      // drain: advance the queue by one beat
      if (rsp_accept) begin
         cnt_in = cnt_ff - 2'd1;
         ch0_in = ch1_ff;
         ch1_in = ch2_ff;
      end

      if (advance) begin
         if (is_end) begin
            // terminating NUL carries the counts, then clear them
            cnt_in     = 2'd1;
            ch0_in     = NUL_CHAR;
            fin_in     = 1'b1;
            wr_in      = written_ff;
            nd_in      = fin_bytes;
            needed_in  = '0;
            written_in = '0;
         end else begin
            fin_in    = 1'b0;
            wr_in     = '0;
            nd_in     = '0;
            needed_in = sum[COUNT_WIDTH] ? CountMax : sum[COUNT_WIDTH-1:0];
            if (fits) begin
               ch0_in = enc.char0;
               ch1_in = enc.char1;
               ch2_in = enc.char2;
               if (enc.plain) begin
                  cnt_in     = 2'd1;
                  written_in = written_ff + 16'd1;
               end else begin
                  cnt_in     = 2'd3;
                  written_in = written_ff + 16'd3;
               end
            end else begin
               cnt_in = 2'd0;
            end
         end
      end
   end

   assign rsp_out_char      = ch0_ff;
   assign rsp_is_final      = fin_ff;
   assign rsp_chars_written = wr_ff;
   assign rsp_bytes_needed  = nd_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oe_ff      <= 1'b1;
         cap_ff     <= CAP_MAX;
         in_vld_ff  <= 1'b0;
         cnt_ff     <= 2'd0;
         needed_ff  <= '0;
         written_ff <= '0;
      end else begin
         oe_ff      <= oe_in;
         cap_ff     <= cap_in;
         in_vld_ff  <= in_vld_in;
         cnt_ff     <= cnt_in;
         needed_ff  <= needed_in;
         written_ff <= written_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      ch0_ff     <= ch0_in;
      ch1_ff     <= ch1_in;
      ch2_ff     <= ch2_in;
      fin_ff     <= fin_in;
      wr_ff      <= wr_in;
      nd_ff      <= nd_in;
   end

endmodule

@@ rtl/core/upe_checker.sv @@
`timescale 1ns / 1ps

module upe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_char,
   input logic        rsp_is_final,
   input logic [15:0] rsp_chars_written,
   input logic [19:0] rsp_bytes_needed
);

   // nothing to deliver right after reset
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // final beat is a NUL with a nonzero size
   a_final_nul: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_final) |-> (rsp_out_char == 8'h00 && rsp_bytes_needed != 20'd0))
      else $error("final beat malformed");

   // counts appear only on the final beat
   a_counts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_final) |->
         (rsp_chars_written == 16'd0 && rsp_bytes_needed == 20'd0))
      else $error("counts on a character beat");

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_char)
                                    && $stable(rsp_is_final)))
      else $error("stalled beat changed");

endmodule

bind url_percent_encoder_top upe_checker u_upe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_char      (rsp_out_char),
   .rsp_is_final      (rsp_is_final),
   .rsp_chars_written (rsp_chars_written),
   .rsp_bytes_needed  (rsp_bytes_needed)
);
